// ----- hw/rtl/sdtq_pkg.sv -----
// Package for the sorted deadline timer queue.
// Holds the cell command type shared by the top level and the timer cells.
// No dependencies.
`default_nettype none

package sdtq_pkg;

	// Width of a timer slot number and of a position in the cell chain.
	localparam int ID_BITS = 4;

	// Largest number of cells the slot numbering can address.
	localparam int ID_SPACE = 16;

	// Command that every cell of the chain sees in the same cycle.
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REMOVE
	} cell_op_t;

	typedef struct packed {
		cell_op_t             op;
		logic [ID_BITS-1:0]   id;
		logic                 kind;
		logic [ID_BITS-1:0]   pos;
	} cell_cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sdtq_cell.sv -----
// One cell of the sorted timer chain: holds one timer entry.
// Depends on sdtq_pkg for the command type.
// Exchanges entries with its left and right neighbors on insert and remove.
`default_nettype none

module sdtq_cell
	import sdtq_pkg::*;
#(
	parameter int TIME_BITS = 48,
	parameter int INDEX     = 0
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cell_cmd_t            cmd,
	input  wire logic [ID_BITS-1:0]   match_id,
	input  wire logic [TIME_BITS-1:0] new_deadline,
	input  wire logic [TIME_BITS-1:0] now,
	input  wire logic                 prev_valid,
	input  wire logic                 prev_le,
	input  wire logic [ID_BITS-1:0]   prev_id,
	input  wire logic                 prev_kind,
	input  wire logic [TIME_BITS-1:0] prev_deadline,
	input  wire logic                 next_valid,
	input  wire logic [ID_BITS-1:0]   next_id,
	input  wire logic                 next_kind,
	input  wire logic [TIME_BITS-1:0] next_deadline,
	output logic                      valid,
	output logic [ID_BITS-1:0]        id,
	output logic                      kind,
	output logic [TIME_BITS-1:0]      deadline,
	output logic                      le,
	output logic                      expired,
	output logic                      match
);

	localparam logic [ID_BITS-1:0] POS_IDX = ID_BITS'(INDEX);

	logic                 valid_q;
	logic [ID_BITS-1:0]   id_q;
	logic                 kind_q;
	logic [TIME_BITS-1:0] deadline_q;

	logic                 valid_d;
	logic [ID_BITS-1:0]   id_d;
	logic                 kind_d;
	logic [TIME_BITS-1:0] deadline_d;

	// Flags seen by the neighbors and the controller.
	assign le      = valid_q && (deadline_q <= new_deadline);
	assign expired = valid_q && (deadline_q < now);
	assign match   = valid_q && (id_q == match_id);

	assign valid    = valid_q;
	assign id       = id_q;
	assign kind     = kind_q;
	assign deadline = deadline_q;

	// Next entry: keep, take the new timer, or take a neighbor's entry.
	always_comb begin
		valid_d    = valid_q;
		id_d       = id_q;
		kind_d     = kind_q;
		deadline_d = deadline_q;
		unique case (cmd.op)
			CELL_INSERT: begin
				if (le) begin
					valid_d = valid_q;
				end else if (prev_le) begin
					valid_d    = 1'b1;
					id_d       = cmd.id;
					kind_d     = cmd.kind;
					deadline_d = new_deadline;
				end else begin
					valid_d    = prev_valid;
					id_d       = prev_id;
					kind_d     = prev_kind;
					deadline_d = prev_deadline;
				end
			end
			CELL_REMOVE: begin
				if (POS_IDX >= cmd.pos) begin
					valid_d    = next_valid;
					id_d       = next_id;
					kind_d     = next_kind;
					deadline_d = next_deadline;
				end
			end
			default: begin
				valid_d = valid_q;
			end
		endcase
	end

	// The valid bit is control state; the entry payload needs no reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		id_q       <= id_d;
		kind_q     <= kind_d;
		deadline_q <= deadline_d;
	end

endmodule

`default_nettype wire

// ----- hw/rtl/sorted_deadline_timer_queue.sv -----
// Sorted deadline timer queue. A schedule or cancel transaction is accepted in the idle
// state, and in the execute state the cell chain inserts or removes the entry in place. A
// check transaction gives one result per fired timer (at least one), because the chain
// shifts its head out by one cell for each result. The execute state waits while the
// result register is still held by the downstream side. The list starts empty after reset
// with no clearing pass. Timers are held in min(TIMER_SLOTS, 16) cells kept in deadline
// order; equal deadlines fire in the order they were scheduled.
// Depends on sdtq_pkg and sdtq_cell.
`default_nettype none

module sorted_deadline_timer_queue
	import sdtq_pkg::*;
#(
	parameter int TIMER_SLOTS = 16,
	parameter int TIME_BITS   = 48
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// From bit 0: timer_id[3:0], delay[30:0], uses_callback, current_time[47:0], zero fill.
	input  wire logic [87:0] s_axis_tdata,
	// From bit 0: opcode[1:0].
	input  wire logic [1:0]  s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// From bit 0: fired_id[3:0], fired_kind, zero fill.
	output logic [7:0]       m_axis_tdata,
	// From bit 0: status[2:0].
	output logic [2:0]       m_axis_tuser,
	output logic             m_axis_tlast
);

	localparam int CAP   = (TIMER_SLOTS < ID_SPACE) ? TIMER_SLOTS : ID_SPACE;
	localparam int CAP_W = ID_BITS + 1;
	localparam int SUM_W = TIME_BITS + 1;

	localparam logic [1:0] OP_SCHEDULE = 2'd0;
	localparam logic [1:0] OP_CANCEL   = 2'd1;

	localparam logic [2:0] ST_SCHEDULED = 3'd0;
	localparam logic [2:0] ST_ACTIVE    = 3'd1;
	localparam logic [2:0] ST_CANCELLED = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_FIRED     = 3'd4;
	localparam logic [2:0] ST_NONE      = 3'd5;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;

	// Latched transaction.
	logic [1:0]           op_q;
	logic [ID_BITS-1:0]   id_q;
	logic                 kind_q;
	logic [TIME_BITS-1:0] now_q;
	logic [TIME_BITS-1:0] deadline_q;

	// Result register.
	logic                 out_valid_q;
	logic [2:0]           out_status_q;
	logic [ID_BITS-1:0]   out_id_q;
	logic                 out_kind_q;
	logic                 out_last_q;

	// Chain signals.
	logic [CAP-1:0]       cell_valid;
	logic [CAP-1:0]       cell_kind;
	logic [CAP-1:0]       cell_le;
	logic [CAP-1:0]       cell_exp;
	logic [CAP-1:0]       cell_match;
	logic [ID_BITS-1:0]   cell_id [CAP];
	logic [TIME_BITS-1:0] cell_dl [CAP];

	cell_cmd_t            cmd;

	logic                 in_accept;
	logic                 out_free;
	logic                 exec_go;
	logic [TIME_BITS-1:0] now_in;
	logic [SUM_W-1:0]     dl_sum;
	logic [TIME_BITS-1:0] dl_in;

	logic [ID_BITS-1:0]   match_pos;
	logic                 match_kind;
	logic                 found;
	logic                 id_bad;
	logic                 full;

	logic [2:0]           res_status;
	logic [ID_BITS-1:0]   res_id;
	logic                 res_kind;
	logic                 res_last;
	logic                 res_done;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign exec_go       = (state_q == S_EXEC) && out_free;

	// Deadline of a new timer, saturated at the top of the time range.
	assign now_in = TIME_BITS'(s_axis_tdata[83:36]);
	assign dl_sum = {1'b0, now_in} + SUM_W'(s_axis_tdata[34:4]);
	assign dl_in  = dl_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : dl_sum[TIME_BITS-1:0];

	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_q       <= s_axis_tuser;
			id_q       <= s_axis_tdata[3:0];
			kind_q     <= s_axis_tdata[35];
			now_q      <= now_in;
			deadline_q <= dl_in;
		end
	end

	// Locate the cell holding the requested slot; slot numbers are unique in the chain.
	always_comb begin
		match_pos  = '0;
		match_kind = 1'b0;
		for (int i = 0; i < CAP; i++) begin
			if (cell_match[i]) begin
				match_pos = match_pos | ID_BITS'(i);
			end
			match_kind = match_kind | (cell_match[i] & cell_kind[i]);
		end
	end

	assign found  = |cell_match;
	assign id_bad = ({1'b0, id_q} >= CAP_W'(CAP));
	assign full   = cell_valid[CAP-1];

	// Decide the result and the chain command for the latched transaction.
	always_comb begin
		cmd.op     = CELL_HOLD;
		cmd.id     = id_q;
		cmd.kind   = kind_q;
		cmd.pos    = match_pos;
		res_status = ST_NONE;
		res_id     = id_q;
		res_kind   = 1'b0;
		res_last   = 1'b1;
		unique case (op_q)
			OP_SCHEDULE: begin
				if (id_bad) begin
					res_status = ST_ACTIVE;
				end else if (found) begin
					res_status = ST_ACTIVE;
					res_kind   = match_kind;
				end else if (full) begin
					res_status = ST_ACTIVE;
				end else begin
					res_status = ST_SCHEDULED;
					res_kind   = kind_q;
					cmd.op     = exec_go ? CELL_INSERT : CELL_HOLD;
				end
			end
			OP_CANCEL: begin
				if (found) begin
					res_status = ST_CANCELLED;
					res_kind   = match_kind;
					cmd.op     = exec_go ? CELL_REMOVE : CELL_HOLD;
				end else begin
					res_status = ST_NOT_FOUND;
				end
			end
			default: begin
				// A check fires the head of the chain while it is expired.
				if (cell_exp[0]) begin
					res_status = ST_FIRED;
					res_id     = cell_id[0];
					res_kind   = cell_kind[0];
					res_last   = !cell_exp[1];
					cmd.pos    = '0;
					cmd.op     = exec_go ? CELL_REMOVE : CELL_HOLD;
				end else begin
					res_status = ST_NONE;
					res_id     = '0;
				end
			end
		endcase
	end

	assign res_done = res_last;

	// Controller state and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_valid_q  <= 1'b0;
			out_status_q <= '0;
			out_id_q     <= '0;
			out_kind_q   <= 1'b0;
			out_last_q   <= 1'b0;
		end else begin
			if (exec_go) begin
				out_valid_q  <= 1'b1;
				out_status_q <= res_status;
				out_id_q     <= res_id;
				out_kind_q   <= res_kind;
				out_last_q   <= res_last;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (exec_go && res_done) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, out_kind_q, out_id_q};
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tlast  = out_last_q;

	// The chain of cells, head at index zero.
	for (genvar g = 0; g < CAP; g++) begin : g_cell
		logic                 p_valid;
		logic                 p_le;
		logic [ID_BITS-1:0]   p_id;
		logic                 p_kind;
		logic [TIME_BITS-1:0] p_dl;
		logic                 n_valid;
		logic [ID_BITS-1:0]   n_id;
		logic                 n_kind;
		logic [TIME_BITS-1:0] n_dl;

		if (g == 0) begin : g_head
			assign p_valid = 1'b0;
			assign p_le    = 1'b1;
			assign p_id    = '0;
			assign p_kind  = 1'b0;
			assign p_dl    = '0;
		end else begin : g_mid
			assign p_valid = cell_valid[g-1];
			assign p_le    = cell_le[g-1];
			assign p_id    = cell_id[g-1];
			assign p_kind  = cell_kind[g-1];
			assign p_dl    = cell_dl[g-1];
		end

		if (g == CAP - 1) begin : g_tail
			assign n_valid = 1'b0;
			assign n_id    = '0;
			assign n_kind  = 1'b0;
			assign n_dl    = '0;
		end else begin : g_body
			assign n_valid = cell_valid[g+1];
			assign n_id    = cell_id[g+1];
			assign n_kind  = cell_kind[g+1];
			assign n_dl    = cell_dl[g+1];
		end

		sdtq_cell #(
			.TIME_BITS (TIME_BITS),
			.INDEX     (g)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.cmd           (cmd),
			.match_id      (id_q),
			.new_deadline  (deadline_q),
			.now           (now_q),
			.prev_valid    (p_valid),
			.prev_le       (p_le),
			.prev_id       (p_id),
			.prev_kind     (p_kind),
			.prev_deadline (p_dl),
			.next_valid    (n_valid),
			.next_id       (n_id),
			.next_kind     (n_kind),
			.next_deadline (n_dl),
			.valid         (cell_valid[g]),
			.id            (cell_id[g]),
			.kind          (cell_kind[g]),
			.deadline      (cell_dl[g]),
			.le            (cell_le[g]),
			.expired       (cell_exp[g]),
			.match         (cell_match[g])
		);
	end

endmodule

`default_nettype wire
